FILE: rtl/icm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icm_pkg
// shared types, constants and generator helpers for the ising lattice block
// ----------------------------------------------------------------------------
package icm_pkg;

    localparam int unsigned LatticeSide = 128;
    localparam int unsigned SideW       = $clog2(LatticeSide);
    localparam int unsigned SiteCount   = LatticeSide * LatticeSide;
    localparam int unsigned SiteW       = 2 * SideW;

    localparam logic [63:0] MixGamma = 64'h9E3779B97F4A7C15;
    localparam logic [63:0] MixMulA  = 64'hBF58476D1CE4E5B9;
    localparam logic [63:0] MixMulB  = 64'h94D049BB133111EB;
    localparam logic [63:0] XsMul    = 64'h2545F4914F6CDD1D;
    localparam logic [63:0] SeedOfs  = 64'h000000009E3779B9;

    localparam logic [31:0] ProbDe4Rst = 32'd736760000;
    localparam logic [31:0] ProbDe8Rst = 32'd126380000;
    localparam logic [63:0] SeedRst    = 64'd1;

    typedef enum logic [1:0] {
        K_RANDOMIZE = 2'd0,
        K_SWEEP     = 2'd1,
        K_READ      = 2'd2,
        K_WRITE     = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        REG_DE4  = 2'd0,
        REG_DE8  = 2'd1,
        REG_SEED = 2'd2
    } t_reg;

    typedef struct packed {
        logic [1:0]  kind;
        logic [13:0] site_index;
        logic        spin_value;
    } t_in_item;

    typedef struct packed {
        logic        spin_out;
        logic [15:0] magnetization;
    } t_out_item;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RAND,
        S_RAND_SEED,
        S_SWEEP,
        S_RD,
        S_WR,
        S_DONE
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic start_rand;
        logic rand_seed;
        logic start_sweep;
        logic rd_issue;
        logic wr_apply;
        logic load_out;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic rand_last;
        logic sweep_last;
    } t_sts;

    function automatic logic [63:0] xs_step(input logic [63:0] x);
        logic [63:0] y;
        y = x ^ (x >> 12);
        y = y ^ (y << 25);
        y = y ^ (y >> 27);
        return y;
    endfunction

endpackage

FILE: rtl/icm_mul64.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icm_mul64
// low 64 bits of a 64x64 product over four stages of 32x32 partial products
// ----------------------------------------------------------------------------
module icm_mul64 (
    input  logic        i_clk,
    input  logic [63:0] i_a,
    input  logic [63:0] i_b,
    output logic [63:0] o_p
);
    logic [63:0] r_ll;
    logic [31:0] r_lh;
    logic [31:0] r_hl;
    logic [63:0] r_sum;
    logic [63:0] r_p;
    logic [63:0] r_ll2;
    logic [31:0] r_cr;

    // partial products, one per slice
    always_ff @(posedge i_clk) begin
        r_ll <= 64'(i_a[31:0]) * 64'(i_b[31:0]);
        r_lh <= 32'(i_a[31:0] * i_b[63:32]);
        r_hl <= 32'(i_a[63:32] * i_b[31:0]);
    end

    // combine cross terms
    always_ff @(posedge i_clk) begin
        r_ll2 <= r_ll;
        r_cr  <= r_lh + r_hl;
    end

    always_ff @(posedge i_clk) begin
        r_sum <= r_ll2 + {r_cr, 32'd0};
        r_p   <= r_sum;
    end

    assign o_p = r_p;
endmodule

FILE: rtl/icm_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icm_ctrl
// command sequencer: decodes items and steps the datapath
// ----------------------------------------------------------------------------
module icm_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [1:0]           i_kind,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    input  icm_pkg::t_sts        i_sts,
    output icm_pkg::t_cmd        o_cmd
);
    icm_pkg::t_state r_state, n_state;
    logic [1:0]      r_wait, n_wait;
    logic            r_ovalid, n_ovalid;

    // next state
    always_comb begin
        n_state  = r_state;
        n_wait   = r_wait;
        n_ovalid = r_ovalid;
        if (r_ovalid && i_out_ready) n_ovalid = 1'b0;
        unique case (r_state)
            icm_pkg::S_IDLE: begin
                if (i_in_valid && !r_ovalid) begin
                    unique case (icm_pkg::t_kind'(i_kind))
                        icm_pkg::K_RANDOMIZE: n_state = icm_pkg::S_RAND;
                        icm_pkg::K_SWEEP:     n_state = icm_pkg::S_SWEEP;
                        icm_pkg::K_READ:      n_state = icm_pkg::S_RD;
                        icm_pkg::K_WRITE:     n_state = icm_pkg::S_WR;
                    endcase
                    n_wait = 2'd0;
                end
            end
            icm_pkg::S_RAND: if (i_sts.rand_last) n_state = icm_pkg::S_RAND_SEED;
            icm_pkg::S_RAND_SEED: if (i_sts.rand_last) n_state = icm_pkg::S_DONE;
            icm_pkg::S_SWEEP: if (i_sts.sweep_last) n_state = icm_pkg::S_DONE;
            icm_pkg::S_RD: n_state = icm_pkg::S_DONE;
            icm_pkg::S_WR: begin
                n_wait = r_wait + 2'd1;
                if (r_wait == 2'd1) n_state = icm_pkg::S_DONE;
            end
            icm_pkg::S_DONE: begin
                n_state  = icm_pkg::S_IDLE;
                n_ovalid = 1'b1;
            end
            default: n_state = icm_pkg::S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd = '0;
        o_in_ready = (r_state == icm_pkg::S_IDLE) && !r_ovalid;
        unique case (r_state)
            icm_pkg::S_IDLE: begin
                if (i_in_valid && !r_ovalid) begin
                    o_cmd.start_rand  = (i_kind == icm_pkg::K_RANDOMIZE);
                    o_cmd.start_sweep = (i_kind == icm_pkg::K_SWEEP);
                    o_cmd.rd_issue    = (i_kind == icm_pkg::K_READ) ||
                                        (i_kind == icm_pkg::K_WRITE);
                end
            end
            icm_pkg::S_RAND_SEED: o_cmd.rand_seed = 1'b1;
            icm_pkg::S_WR: begin
                o_cmd.wr_apply = (r_wait == 2'd0);
            end
            icm_pkg::S_DONE: o_cmd.load_out = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= icm_pkg::S_IDLE;
            r_wait   <= 2'd0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_wait   <= n_wait;
            r_ovalid <= n_ovalid;
        end
    end

    assign o_out_valid = r_ovalid;

    a_busy_no_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != icm_pkg::S_IDLE) |-> !o_in_ready) else $error("ready while busy");
    a_done_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == icm_pkg::S_DONE) |=> r_ovalid) else $error("result lost");
    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.start_rand, o_cmd.start_sweep, o_cmd.rd_issue, o_cmd.load_out}))
        else $error("conflicting commands");
endmodule

FILE: rtl/icm_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icm_datapath
// lattice memory, generators, row window and metropolis update
// ----------------------------------------------------------------------------
module icm_datapath (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  icm_pkg::t_cmd        i_cmd,
    output icm_pkg::t_sts        o_sts,
    input  icm_pkg::t_in_item    i_item,
    input  logic [31:0]          i_de4,
    input  logic [31:0]          i_de8,
    input  logic [63:0]          i_seed,
    output icm_pkg::t_out_item   o_item
);
    localparam int unsigned N  = icm_pkg::LatticeSide;
    localparam int unsigned SW = icm_pkg::SideW;
    localparam int unsigned AW = icm_pkg::SiteW;
    localparam int unsigned RandLat = 11;

    // lattice stored by row, one row per word
    logic [N-1:0] r_mem [N];
    logic [N-1:0] r_rdq;

    logic [63:0]  r_rng;
    logic [15:0]  r_sum;
    logic [AW-1:0] r_site;
    logic         r_site_ok;
    logic         r_wval;
    logic         r_is_rd;

    // ---------------- randomize: pipelined splitmix64 --------------------
    logic [63:0] r_mix_s;
    logic [AW:0] r_issue;
    logic [AW:0] r_got;
    logic        r_issue_on;
    logic [63:0] r_z0, r_z1a, r_z2a;
    logic [63:0] m1_p, m2_p;
    logic [RandLat-1:0] r_vpipe;
    logic [N-1:0] r_rowbuf;
    logic [15:0]  r_upcnt;
    logic         r_seed_mode;

    always_ff @(posedge i_clk) begin
        r_z0 <= r_mix_s + icm_pkg::MixGamma;
    end
    icm_mul64 u_m1 (.i_clk(i_clk), .i_a(r_z0 ^ (r_z0 >> 30)), .i_b(icm_pkg::MixMulA),
                    .o_p(m1_p));
    always_ff @(posedge i_clk) r_z1a <= m1_p ^ (m1_p >> 27);
    icm_mul64 u_m2 (.i_clk(i_clk), .i_a(r_z1a), .i_b(icm_pkg::MixMulB), .o_p(m2_p));
    always_ff @(posedge i_clk) r_z2a <= m2_p ^ (m2_p >> 31);

    // issue/track control of the mixer pipe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_issue_on <= 1'b0;
            r_vpipe    <= '0;
            r_issue    <= '0;
            r_got      <= '0;
            r_seed_mode <= 1'b0;
        end else begin
            r_vpipe <= {r_vpipe[RandLat-2:0], r_issue_on};
            if (i_cmd.start_rand) begin
                r_issue_on  <= 1'b1;
                r_issue     <= '0;
                r_got       <= '0;
                r_seed_mode <= 1'b0;
            end else if (i_cmd.rand_seed && !r_seed_mode) begin
                r_seed_mode <= 1'b1;
                r_issue_on  <= 1'b1;
                r_issue     <= (AW+1)'(icm_pkg::SiteCount - 1);
                r_got       <= (AW+1)'(icm_pkg::SiteCount - 1);
            end else if (r_issue_on) begin
                r_issue <= r_issue + 1'b1;
                if (r_seed_mode || r_issue == (AW+1)'(icm_pkg::SiteCount - 1))
                    r_issue_on <= 1'b0;
            end
            if (r_vpipe[RandLat-1]) r_got <= r_got + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start_rand) r_mix_s <= i_seed;
        else if (i_cmd.rand_seed && !r_seed_mode) r_mix_s <= i_seed + icm_pkg::SeedOfs;
        else if (r_issue_on) r_mix_s <= r_mix_s + icm_pkg::MixGamma;
    end

    assign o_sts.rand_last = r_seed_mode ? (r_vpipe[RandLat-1] && !r_issue_on)
                                         : (r_vpipe[RandLat-1] &&
                                            r_got == (AW+1)'(icm_pkg::SiteCount - 1));

    // ---- sweep: site scan, one site per cycle save row loads and draws ----
    // phases: each row loaded, neighbours from row above/below buffered, row written back
    logic         r_color;
    logic [SW-1:0] r_row;
    logic [SW:0]  r_col;
    logic [2:0]   r_ph;
    logic [N-1:0] r_rup, r_rcur, r_rdn;
    logic         r_sw_on;
    logic [63:0]  xs_p;
    logic [3:0]   r_mw;
    logic         r_last;

    localparam logic [2:0] P_LDUP = 3'd0, P_LDCUR = 3'd1, P_LDDN = 3'd2,
                           P_WAIT = 3'd3, P_SITE = 3'd4, P_MUL = 3'd5, P_WB = 3'd6;

    logic [SW-1:0] rup_i, rdn_i;
    assign rup_i = r_row - 1'b1;
    assign rdn_i = r_row + 1'b1;

    logic [SW-1:0] cidx, cl, cr;
    assign cidx = r_col[SW-1:0];
    assign cl = cidx - 1'b1;
    assign cr = cidx + 1'b1;

    logic s_c;
    logic [2:0] nb_up;
    logic       de_le0, de_is4;
    always_comb begin
        s_c   = r_rcur[cidx];
        nb_up = 3'(r_rup[cidx]) + 3'(r_rdn[cidx]) + 3'(r_rcur[cl]) + 3'(r_rcur[cr]);
        // aligned neighbours: s up -> nb_up counts aligned, down -> 4-nb_up
        de_le0 = s_c ? (nb_up <= 3'd2) : (nb_up >= 3'd2);
        de_is4 = s_c ? (nb_up == 3'd3) : (nb_up == 3'd1);
    end

    logic [63:0] xs_nx;
    assign xs_nx = icm_pkg::xs_step(r_rng);
    icm_mul64 u_m3 (.i_clk(i_clk), .i_a(r_rng), .i_b(icm_pkg::XsMul), .o_p(xs_p));

    logic         rd_en;
    logic [SW-1:0] rd_a;
    logic         wr_en;
    logic [SW-1:0] wr_a;
    logic [N-1:0] wr_d;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sw_on <= 1'b0;
            r_ph    <= P_LDUP;
            r_mw    <= '0;
            r_last  <= 1'b0;
            r_rng   <= '0;
        end else begin
            r_last <= 1'b0;
            if (i_cmd.start_sweep) begin
                r_sw_on <= 1'b1;
                r_color <= 1'b0;
                r_row   <= '0;
                r_ph    <= P_LDUP;
            end else if (r_sw_on) begin
                unique case (r_ph)
                    P_LDUP:  r_ph <= P_LDCUR;
                    P_LDCUR: begin r_rup <= r_rdq; r_ph <= P_LDDN; end
                    P_LDDN:  begin r_rcur <= r_rdq; r_ph <= P_WAIT; end
                    P_WAIT: begin
                        r_rdn <= r_rdq;
                        r_col <= (SW+1)'(r_row[0] ^ r_color);
                        r_ph  <= P_SITE;
                    end
                    P_SITE: begin
                        if (r_col >= (SW+1)'(N)) begin
                            r_ph <= P_WB;
                        end else if (de_le0) begin
                            r_rcur[cidx] <= ~s_c;
                            r_col <= r_col + 2'd2;
                        end else begin
                            r_rng <= xs_nx;
                            r_mw  <= '0;
                            r_ph  <= P_MUL;
                        end
                    end
                    P_MUL: begin
                        // product of the stepped state comes out of the mul pipe; r_mw counts the wait
                        r_mw <= r_mw + 1'b1;
                        if (r_mw == 4'd4) begin
                            if (xs_p[63:32] < (de_is4 ? i_de4 : i_de8))
                                r_rcur[cidx] <= ~s_c;
                            r_col <= r_col + 2'd2;
                            r_ph  <= P_SITE;
                        end
                    end
                    P_WB: begin
                        r_ph <= P_LDUP;
                        r_row <= r_row + 1'b1;
                        if (r_row == SW'(N-1)) begin
                            if (r_color) begin
                                r_sw_on <= 1'b0;
                                r_last  <= 1'b1;
                            end
                            r_color <= ~r_color;
                        end
                    end
                    default: r_ph <= P_LDUP;
                endcase
            end
            if (i_cmd.rand_seed && o_sts.rand_last) r_rng <= r_z2a;
        end
    end
    assign o_sts.sweep_last = r_last;

    // xorshift result used after the mul pipe: product of the state after the step
    // (multiplier sees r_rng already stepped, which is the drawn value)

    // ---------------- memory ports ----------------
    logic [N-1:0] wrow;
    always_comb begin
        wrow = r_rdq;
        wrow[r_site[SW-1:0]] = r_wval;
    end

    always_comb begin
        rd_en = 1'b0; rd_a = '0;
        wr_en = 1'b0; wr_a = '0; wr_d = '0;
        if (r_sw_on && r_ph == P_LDUP) begin rd_en = 1'b1; rd_a = rup_i; end
        if (r_sw_on && r_ph == P_LDCUR) begin rd_en = 1'b1; rd_a = r_row; end
        if (r_sw_on && r_ph == P_LDDN) begin rd_en = 1'b1; rd_a = rdn_i; end
        if (i_cmd.rd_issue) begin
            rd_en = 1'b1; rd_a = i_item.site_index[AW-1:SW];
        end
        if (r_sw_on && r_ph == P_WB) begin
            wr_en = 1'b1; wr_a = r_row; wr_d = r_rcur;
        end
        if (i_cmd.wr_apply && r_site_ok) begin
            wr_en = 1'b1; wr_a = r_site[AW-1:SW]; wr_d = wrow;
        end
        if (r_vpipe[RandLat-1] && !r_seed_mode && r_got[SW-1:0] == SW'(N-1)) begin
            wr_en = 1'b1; wr_a = r_got[AW-1:SW];
            wr_d = {r_z2a[0], r_rowbuf[N-1:1]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) r_mem[wr_a] <= wr_d;
        if (rd_en) r_rdq <= r_mem[rd_a];
    end

    // row assembly for randomize
    always_ff @(posedge i_clk) begin
        if (r_vpipe[RandLat-1] && !r_seed_mode)
            r_rowbuf <= {r_z2a[0], r_rowbuf[N-1:1]};
    end

    // ---------------- running sum, read/write ----------------
    logic sweep_flip;
    logic [15:0] sum_full;
    assign sum_full = 16'(2 * 32'(r_upcnt) - icm_pkg::SiteCount);
    assign sweep_flip = r_sw_on && ((r_ph == P_SITE && r_col < (SW+1)'(N) && de_le0) ||
                        (r_ph == P_MUL && r_mw == 4'd4 &&
                         xs_p[63:32] < (de_is4 ? i_de4 : i_de8)));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
            r_upcnt <= '0;
        end else begin
            if (i_cmd.start_rand) r_upcnt <= '0;
            else if (r_vpipe[RandLat-1] && !r_seed_mode)
                r_upcnt <= r_upcnt + 16'(r_z2a[0]);
            if (i_cmd.rand_seed && o_sts.rand_last) r_sum <= sum_full;
            else if (sweep_flip) r_sum <= s_c ? r_sum - 16'd2 : r_sum + 16'd2;
            else if (i_cmd.wr_apply && r_site_ok &&
                     r_rdq[r_site[SW-1:0]] != r_wval)
                r_sum <= r_wval ? r_sum + 16'd2 : r_sum - 16'd2;
        end
    end

    // item capture on accept, result load
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_issue || i_cmd.start_rand || i_cmd.start_sweep)
            r_is_rd <= (i_item.kind == icm_pkg::K_READ);
        if (i_cmd.rd_issue) begin
            r_site    <= i_item.site_index[AW-1:0];
            r_site_ok <= (15'(i_item.site_index) < 15'(icm_pkg::SiteCount));
            r_wval    <= i_item.spin_value;
        end
        if (i_cmd.load_out) begin
            o_item.spin_out      <= r_is_rd && r_site_ok && r_rdq[r_site[SW-1:0]];
            o_item.magnetization <= r_sum;
        end
    end

    a_sum_even: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_sum[0]) else $error("sum parity");
    a_no_dual_ops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_sw_on && r_issue_on)) else $error("sweep and fill overlap");
    a_mul_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ph == P_MUL) |-> (r_mw <= 4'd4)) else $error("mul wait overrun");
endmodule

FILE: rtl/ising_checkerboard_metropolis.sv
`timescale 1ns / 1ps
// read and write items wait on the lattice row read and write ports; randomize
// and sweep also wait on them and on the 4-stage 64-bit multipliers
// throughput: one item at a time; the next item is taken once the result is taken
// reset: synchronous active low; control and config registers to their reset values, lattice undefined
// ----------------------------------------------------------------------------
// ising_checkerboard_metropolis
// 2d ising lattice with checkerboard metropolis sweeps, apb register port
// ----------------------------------------------------------------------------
module ising_checkerboard_metropolis (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  icm_pkg::t_in_item      i_item,
    output logic                   o_valid,
    input  logic                   i_ready,
    output icm_pkg::t_out_item     o_item,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [4:0]             paddr,
    input  logic [63:0]            pwdata,
    output logic [63:0]            prdata,
    output logic                   pready
);
    logic [31:0] r_de4, r_de8;
    logic [63:0] r_seed;
    icm_pkg::t_cmd cmd;
    icm_pkg::t_sts sts;
    logic [1:0] ridx;

    assign pready = 1'b1;
    assign ridx = paddr[4:3];

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_de4  <= icm_pkg::ProbDe4Rst;
            r_de8  <= icm_pkg::ProbDe8Rst;
            r_seed <= icm_pkg::SeedRst;
        end else if (psel && penable && pwrite && paddr[2:0] == 3'd0) begin
            unique case (ridx)
                icm_pkg::REG_DE4:  r_de4  <= pwdata[31:0];
                icm_pkg::REG_DE8:  r_de8  <= pwdata[31:0];
                icm_pkg::REG_SEED: r_seed <= pwdata;
                default: ;
            endcase
        end
    end

    // register reads
    always_comb begin
        prdata = '0;
        unique case (ridx)
            icm_pkg::REG_DE4:  prdata = 64'(r_de4);
            icm_pkg::REG_DE8:  prdata = 64'(r_de8);
            icm_pkg::REG_SEED: prdata = r_seed;
            default: prdata = '0;
        endcase
    end

    icm_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(i_valid), .o_in_ready(o_ready),
        .i_kind(i_item.kind), .o_out_valid(o_valid), .i_out_ready(i_ready),
        .i_sts(sts), .o_cmd(cmd)
    );

    icm_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .o_sts(sts), .i_item(i_item),
        .i_de4(r_de4), .i_de8(r_de8), .i_seed(r_seed), .o_item(o_item)
    );
endmodule
